// File: rtl/slt_pkg.sv
`default_nettype none

package slt_pkg;

    localparam int DEPTH_DEF = 16;

    typedef enum logic [1:0] {
        OP_APPEND  = 2'd0,
        OP_INSERT  = 2'd1,
        OP_REPLACE = 2'd2,
        OP_READ    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_RANGE     = 3'd4
    } status_t;

    typedef struct packed {
        op_t                operation;
        logic signed [31:0] value;
        logic signed [31:0] new_value;
        logic [3:0]         position;
    } in_word_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] read_data;
        logic [4:0]         entry_count;
    } out_word_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic decide;
        logic insert;
        logic finish;
    } slt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_insert;
        logic out_free;
    } slt_sts_t;

endpackage

`default_nettype wire

// File: rtl/slt_ctrl.sv
`default_nettype none

module slt_ctrl
    import slt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire slt_sts_t sts,
    output slt_cmd_t      cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EVAL   = 4'b0010,
        S_INSERT = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.decide = 1'b1;
                state_next = sts.need_insert ? S_INSERT : S_FINISH;
            end
            S_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // hold until the output register can take the word
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.decide, cmd.insert, cmd.finish}))
        else $error("controller issued more than one command");

    a_insert_then_finish: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_INSERT |=> state_reg == S_FINISH)
        else $error("insertion pass not followed by finish");

    a_insert_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_INSERT |-> $past(state_reg) == S_EVAL)
        else $error("insertion pass entered without a removal");

endmodule

`default_nettype wire

// File: rtl/slt_datapath.sv
`default_nettype none

module slt_datapath
    import slt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire in_word_t  in_word,
    input  wire slt_cmd_t  cmd,
    output slt_sts_t       sts,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_word_t      out_word
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > 4) ? CW : 4;

    in_word_t           item_reg;
    logic signed [31:0] cells_reg [DEPTH];
    logic signed [31:0] cells_next [DEPTH];
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    status_t            status_reg;
    status_t            status_next;
    logic signed [31:0] rdata_reg;
    logic signed [31:0] rdata_next;
    logic               out_valid_reg;
    out_word_t          out_word_reg;

    logic               empty;
    logic               full;
    logic               found;
    logic               in_range;
    logic signed [31:0] ins_val;
    logic               tail_mode;
    logic signed [31:0] read_mux;
    logic [DEPTH-1:0]   hit;
    logic [DEPTH-1:0]   eq;
    logic signed [31:0] ins_cells [DEPTH];
    logic signed [31:0] rem_cells [DEPTH];
    logic               ins_before;
    logic               rem_seen;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(DEPTH));
    assign in_range = PW'(item_reg.position) < PW'(count_reg);

    // insertion value: old value on the first pass, new value after a removal
    assign ins_val   = cmd.insert ? item_reg.new_value : item_reg.value;
    assign tail_mode = (item_reg.operation == OP_APPEND) && !cmd.insert;

    // all cells compare in parallel, by index for append, else by value
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (tail_mode)
                hit[i] = (CW'(i) == count_reg);
            else if (i == 0)
                hit[i] = empty || (ins_val < cells_reg[0]);
            else
                hit[i] = (CW'(i) == count_reg)
                      || ((CW'(i) < count_reg) && (ins_val <= cells_reg[i]));
            eq[i] = (CW'(i) < count_reg) && (cells_reg[i] == item_reg.value);
        end
    end

    assign found = |eq;

    // cells past the first hit shift toward the tail
    always_comb
    begin
        ins_before = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (ins_before)
                ins_cells[i] = cells_reg[i-1];
            else if (hit[i])
                ins_cells[i] = ins_val;
            else
                ins_cells[i] = cells_reg[i];
            ins_before = ins_before | hit[i];
        end
    end

    // cells from the first match on pull from the one behind
    always_comb
    begin
        rem_seen = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rem_seen = rem_seen | eq[i];
            if (rem_seen && (i < DEPTH - 1))
                rem_cells[i] = cells_reg[i+1];
            else
                rem_cells[i] = cells_reg[i];
        end
    end

    always_comb
    begin
        read_mux = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (PW'(i) == PW'(item_reg.position))
                read_mux = cells_reg[i];
        end
    end

    always_comb
    begin
        cells_next  = cells_reg;
        count_next  = count_reg;
        status_next = status_reg;
        rdata_next  = rdata_reg;
        if (cmd.decide)
        begin
            status_next = ST_OK;
            rdata_next  = '0;
            case (item_reg.operation)
                OP_APPEND:
                begin
                    if (full)
                        status_next = ST_FULL;
                    else
                    begin
                        cells_next = ins_cells;
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_INSERT:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else if (full)
                        status_next = ST_FULL;
                    else
                    begin
                        cells_next = ins_cells;
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_REPLACE:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else if (!found)
                        status_next = ST_NOT_FOUND;
                    else
                    begin
                        cells_next = rem_cells;
                        count_next = count_reg - 1'b1;
                    end
                end
                OP_READ:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else if (!in_range)
                        status_next = ST_RANGE;
                    else
                        rdata_next = read_mux;
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
        else if (cmd.insert)
        begin
            cells_next = ins_cells;
            count_next = count_reg + 1'b1;
        end
    end

    assign sts.need_insert = (item_reg.operation == OP_REPLACE) && !empty && found;
    assign sts.out_free    = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        cells_reg <= cells_next;
        if (cmd.load)
            item_reg <= in_word;
        status_reg <= status_next;
        rdata_reg  <= rdata_next;
        if (cmd.finish)
        begin
            out_word_reg.status      <= status_reg;
            out_word_reg.read_data   <= rdata_reg;
            out_word_reg.entry_count <= 5'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |-> count_reg < CW'(DEPTH))
        else $error("insertion pass on a full list");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.finish))
        else $error("output word raised without finish");

endmodule

`default_nettype wire

// File: rtl/sorted_list_table.sv
// Sorted list table: holds up to DEPTH signed 32-bit entries in a row of cells,
// head first, and runs one operation per input word (append, sorted insert,
// replace, read), returning one output word with status, read data and the
// entry count after the operation. A word passes through the sequencer steps
// accept, one compare-and-shift pass and output load; a replace that finds its
// old value adds a second pass, since its removal shift and its insertion shift
// are two passes over the cell row. A stalled output word holds the sequencer
// in its finish step, and a new input word is taken once the previous word has
// moved to the output register. Reset clears the entry count, the sequencer
// and the output valid flag but not the cells; no clearing pass runs, and the
// block accepts input as soon as reset is released.
`default_nettype none

module sorted_list_table
    import slt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_word_t  in_word,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_word_t      out_word
);

    slt_cmd_t cmd;
    slt_sts_t sts;

    slt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    slt_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

endmodule

`default_nettype wire

// File: tb/tb_sorted_list_table.sv
`timescale 1ns / 100ps

module tb_sorted_list_table;
    import slt_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 370;

    typedef struct {
        in_word_t  stim;
        bit        typed;
        out_word_t reply;
    } step_row_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    in_word_t  in_word   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    out_word_t out_word;

    logic signed [31:0] list_vals [DEPTH];
    int                 list_len      = 0;
    out_word_t          reply_q [$];
    step_row_t          dir_rows [$];
    int                 mismatch_count = 0;
    int                 stall_cycles   = 0;
    int                 send_idle_pct  = 33;
    int                 recv_idle_pct  = 63;

    sorted_list_table u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    always #2 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic void put_entry(input int at, input logic signed [31:0] v);
        for (int i = list_len; i > at; i--)
            list_vals[i] = list_vals[i - 1];
        list_vals[at] = v;
        list_len++;
    endfunction

    // list_len is nonzero and below DEPTH here; order of the entries is not assumed
    function automatic void sorted_put(input logic signed [31:0] v);
        int at;
        if (v < list_vals[0])
        begin
            put_entry(0, v);
        end
        else
        begin
            at = 1;
            while (at < list_len && v > list_vals[at])
                at++;
            put_entry(at, v);
        end
    endfunction

    function automatic out_word_t list_op(input in_word_t w);
        out_word_t          r;
        logic signed [31:0] v;
        logic signed [31:0] nv;
        int                 hit;
        v  = w.value;
        nv = w.new_value;
        r.status    = ST_OK;
        r.read_data = '0;
        case (w.operation)
            OP_APPEND:
                if (list_len >= DEPTH) r.status = ST_FULL;
                else put_entry(list_len, v);
            OP_INSERT:
                if (list_len == 0) r.status = ST_EMPTY;
                else if (list_len >= DEPTH) r.status = ST_FULL;
                else sorted_put(v);
            OP_REPLACE:
                if (list_len == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    hit = -1;
                    for (int i = 0; i < list_len; i++)
                        if (hit < 0 && list_vals[i] == v) hit = i;
                    if (hit < 0)
                    begin
                        r.status = ST_NOT_FOUND;
                    end
                    else
                    begin
                        for (int i = hit; i + 1 < list_len; i++)
                            list_vals[i] = list_vals[i + 1];
                        list_len--;
                        // removing the only entry leaves the new value alone
                        if (list_len == 0) put_entry(0, nv);
                        else sorted_put(nv);
                    end
                end
            default:
                if (list_len == 0) r.status = ST_EMPTY;
                else if (w.position >= list_len) r.status = ST_RANGE;
                else r.read_data = list_vals[w.position];
        endcase
        r.entry_count = list_len[4:0];
        return r;
    endfunction

    function automatic logic signed [31:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 25)
            return $urandom;
        if (roll < 60)
            return $urandom_range(0, 12) - 6;
        if (roll < 80 || list_len == 0)
        begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
        return list_vals[$urandom_range(0, list_len - 1)] + ($urandom_range(0, 2) - 1);
    endfunction

    function automatic in_word_t make_item();
        in_word_t    w;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        w.operation = roll < 8  ? OP_APPEND :
                      roll < 16 ? OP_INSERT :
                      roll < 62 ? OP_REPLACE : OP_READ;
        w.value     = pick_value();
        w.new_value = pick_value();
        w.position  = 4'($urandom_range(0, 15));
        // mostly hit an entry that is there, so replace gets past the search
        if (w.operation == OP_REPLACE && list_len != 0 && $urandom_range(0, 99) < 70)
            w.value = list_vals[$urandom_range(0, list_len - 1)];
        return w;
    endfunction

    function automatic void add_row(input op_t op, input int v, input int nv, input int p,
                                    input bit typed, input status_t st = ST_OK,
                                    input int rd = 0, input int cnt = 0);
        step_row_t r;
        r.stim.operation   = op;
        r.stim.value       = v;
        r.stim.new_value   = nv;
        r.stim.position    = p[3:0];
        r.typed            = typed;
        r.reply.status     = st;
        r.reply.read_data  = rd;
        r.reply.entry_count = cnt[4:0];
        dir_rows.push_back(r);
    endfunction

    task automatic send_word(input in_word_t w, input bit typed, input out_word_t typed_reply);
        out_word_t r;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
        r = list_op(w);
        reply_q.push_back(typed ? typed_reply : r);
    endtask

    // hold off the sender until every pending reply is back
    task automatic drain_replies();
        @(negedge clk);
        in_valid <= 1'b0;
        while (reply_q.size() != 0)
            @(posedge clk);
    endtask

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (reply_q.size() == 0)
            begin
                report_mismatch("output word with no reply pending");
            end
            else
            begin
                want = reply_q.pop_front();
                if (out_word.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              out_word.status, want.status));
                if (out_word.read_data !== want.read_data)
                    report_mismatch($sformatf("read_data %h, want %h",
                                              out_word.read_data, want.read_data));
                if (out_word.entry_count !== want.entry_count)
                    report_mismatch($sformatf("entry_count %0d, want %0d",
                                              out_word.entry_count, want.entry_count));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_sorted_list_table failed");
            $finish;
        end
    end

    initial
    begin
        // empty list refuses everything but append
        add_row(OP_READ,    0, 0, 0, 1'b1, ST_EMPTY, 0, 0);
        add_row(OP_INSERT,  5, 0, 0, 1'b1, ST_EMPTY, 0, 0);
        add_row(OP_REPLACE, 1, 2, 0, 1'b1, ST_EMPTY, 0, 0);
        add_row(OP_APPEND,  32'h7fff_ffff, 0, 0, 1'b1, ST_OK, 0, 1);
        add_row(OP_READ,    0, 0, 15, 1'b1, ST_RANGE, 0, 1);
        // sole entry replaced
        add_row(OP_REPLACE, 32'h7fff_ffff, 32'h8000_0000, 0, 1'b1, ST_OK, 0, 1);
        add_row(OP_READ,    0, 0, 0, 1'b1, ST_OK, 32'h8000_0000, 1);
        add_row(OP_REPLACE, 3, 4, 0, 1'b1, ST_NOT_FOUND, 0, 1);
        // equal to head, below nothing, then unsorted contents
        add_row(OP_INSERT,  32'h8000_0000, 0, 0, 1'b0);
        add_row(OP_INSERT,  -5, 0, 0, 1'b0);
        add_row(OP_APPEND,  -100, 0, 0, 1'b0);
        add_row(OP_INSERT,  -50, 0, 0, 1'b0);
        add_row(OP_INSERT,  32'h7fff_ffff, 0, 0, 1'b0);
        add_row(OP_READ,    0, 0, 5, 1'b0);
        for (int i = 0; i < 10; i++)
            add_row(OP_APPEND, i * 7 - 30, 0, 0, 1'b0);
        // full list
        add_row(OP_APPEND,  1, 0, 0, 1'b1, ST_FULL, 0, 16);
        add_row(OP_INSERT,  1, 0, 0, 1'b1, ST_FULL, 0, 16);
        add_row(OP_REPLACE, 32'h8000_0000, -1, 0, 1'b0);
        add_row(OP_READ,    0, 0, 15, 1'b0);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_word(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].reply);
        drain_replies();

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 63 : 0;
            recv_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 33 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 120 == 119)
                    drain_replies();
                send_word(make_item(), 1'b0, '0);
            end
            drain_replies();
        end

        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_sorted_list_table passed");
        else
            $display("tb_sorted_list_table failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/slt_pkg.sv
rtl/slt_ctrl.sv
rtl/slt_datapath.sv
rtl/sorted_list_table.sv
tb/tb_sorted_list_table.sv
